// ===== design/efc_pkg.sv =====
// Shared constants for the edge frequency counter with glitch filter.
// No dependencies; imported by the top level and its checker.
package efc_pkg;

    localparam int RING_DEPTH_DEF = 8;

    localparam int TS_W       = 32;
    localparam int PERIOD_W   = 24;
    localparam int THR_W      = 22;
    localparam int USED_OUT_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(10000000);

    localparam int THR_NUM   = 15;
    localparam int THR_DEN   = 100;
    localparam int SCALED_W  = PERIOD_W + 4;
    localparam int DVS_W     = 7;

    // floor(x / THR_DEN) as (x * THR_RECIP) >> THR_SHIFT for x below 2**SCALED_W
    localparam int RECIP_W   = 29;
    localparam int THR_SHIFT = 35;
    localparam logic [RECIP_W-1:0] THR_RECIP = RECIP_W'(343597384);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 1'b1;

endpackage

// ===== design/efc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Used by the average step; no dependencies.
module efc_div #(
    parameter int DIVIDEND_W = 30,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/edge_frequency_counter_deglitch.sv =====
// Channel   | valid        | ready        | payload
// edge/req  | i_in_valid   | o_in_ready   | i_func, i_timestamp_us
// report    | o_out_valid  | i_out_ready  | o_tick_count, o_average_period,
//           |              |              | o_glitch_threshold, o_gaps_used
// config    | i_cfg_wr_en  | (none)       | i_cfg_addr, i_cfg_wdata
//
// Edge beat: applied at acceptance.
// Report beat: input held off through the ring walk, the serial divider for the average,
// the scaling step and the emit, which waits while the output register is still full.
// Reset: synchronous, no clearing pass; ring entries read as zero until written.
// A finished report holds in the output register while edges keep flowing in.
// Top level: ring, sequencer and output register; uses efc_pkg and efc_div.
module edge_frequency_counter_deglitch
    import efc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [TS_W-1:0]       i_timestamp_us,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TS_W-1:0]       o_tick_count,
    output logic [PERIOD_W-1:0]   o_average_period,
    output logic [THR_W-1:0]      o_glitch_threshold,
    output logic [USED_OUT_W-1:0] o_gaps_used,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [PERIOD_W-1:0]   i_cfg_wdata
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int SUM_W  = PERIOD_W + PTR_W;
    localparam int DIV_W  = SUM_W;
    localparam int PROD_W = SCALED_W + RECIP_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] LAST_GAP  = PTR_W'(RING_DEPTH - 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DIV1  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]            r_state;
    logic [PERIOD_W-1:0]   r_min_period;
    logic [PERIOD_W-1:0]   r_max_period;
    logic [TS_W-1:0]       r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [PTR_W-1:0]      r_wptr;
    logic [TS_W-1:0]       r_total;
    logic [TS_W-1:0]       r_last;
    logic                  r_armed;
    logic [THR_W-1:0]      r_min_gap;
    logic [PTR_W-1:0]      r_pos;
    logic [PTR_W-1:0]      r_k;
    logic [TS_W-1:0]       r_rd_data;
    logic                  r_rd_vld;
    logic [TS_W-1:0]       r_prev;
    logic [SUM_W-1:0]      r_sum;
    logic [PTR_W-1:0]      r_used;
    logic [PERIOD_W-1:0]   r_avg;
    logic [THR_W-1:0]      r_thr;
    logic                  r_out_valid;
    logic [TS_W-1:0]       r_out_tick;
    logic [PERIOD_W-1:0]   r_out_avg;
    logic [THR_W-1:0]      r_out_thr;
    logic [USED_OUT_W-1:0] r_out_used;

    logic                  in_fire;
    logic                  edge_fire;
    logic                  rep_fire;
    logic [PTR_W-1:0]      rd_addr;
    logic [TS_W-1:0]       edge_gap;
    logic                  edge_counts;
    logic [TS_W-1:0]       rd_word;
    logic [TS_W-1:0]       ring_gap;
    logic                  gap_keep;
    logic [SCALED_W-1:0]   scaled;
    logic [PROD_W-1:0]     thr_prod;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;
    logic                  emit_go;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign edge_fire  = in_fire && !i_func;
    assign rep_fire   = in_fire && i_func;

    assign edge_gap    = i_timestamp_us - r_last;
    assign edge_counts = !edge_gap[TS_W-1] && (edge_gap >= TS_W'(r_min_gap));

    assign rd_addr  = (r_state == S_IDLE) ? r_wptr : r_pos;
    assign rd_word  = r_rd_vld ? r_rd_data : '0;
    assign ring_gap = rd_word - r_prev;
    assign gap_keep = !ring_gap[TS_W-1] && (ring_gap != '0)
                      && (ring_gap > TS_W'(r_min_period))
                      && (ring_gap < TS_W'(r_max_period));

    assign scaled   = {r_avg, 4'b0000} - SCALED_W'(r_avg);
    assign thr_prod = PROD_W'(scaled) * PROD_W'(THR_RECIP);
    assign emit_go  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(r_sum);
        div_divisor  = DVS_W'(r_used);
        if ((r_state == S_WALK) && (r_k == LAST_GAP)) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(r_sum) + (gap_keep ? DIV_W'(ring_gap) : '0);
            div_divisor  = DVS_W'(r_used) + (gap_keep ? DVS_W'(1) : '0);
        end
    end

    efc_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (edge_fire && r_armed) begin
            r_ring[r_wptr] <= i_timestamp_us;
        end
        r_rd_data <= r_ring[rd_addr];
        r_rd_vld  <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST;
            r_max_period <= MAX_PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_MIN_PERIOD: r_min_period <= i_cfg_wdata;
                REG_MAX_PERIOD: r_max_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_wptr      <= '0;
            r_total     <= '0;
            r_last      <= '0;
            r_armed     <= 1'b0;
            r_min_gap   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (edge_fire) begin
                        if (!r_armed) begin
                            r_armed <= 1'b1;
                            r_last  <= i_timestamp_us;
                            r_total <= r_total + TS_W'(1);
                        end else begin
                            r_valid[r_wptr] <= 1'b1;
                            r_wptr          <= next_slot(r_wptr);
                            if (edge_counts) begin
                                r_last  <= i_timestamp_us;
                                r_total <= r_total + TS_W'(1);
                            end
                        end
                    end else if (rep_fire) begin
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: r_state <= S_WALK;
                S_WALK: begin
                    if (r_k == LAST_GAP) begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_EMIT;
                S_EMIT: begin
                    if (emit_go) begin
                        r_min_gap   <= r_thr;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pos <= next_slot(r_wptr);
                r_k   <= '0;
                r_sum <= '0;
                r_used <= '0;
            end
            S_FIRST: begin
                r_prev <= rd_word;
                r_pos  <= next_slot(r_pos);
            end
            S_WALK: begin
                r_prev <= rd_word;
                r_pos  <= next_slot(r_pos);
                r_k    <= r_k + PTR_W'(1);
                if (gap_keep) begin
                    r_sum  <= r_sum + SUM_W'(ring_gap);
                    r_used <= r_used + PTR_W'(1);
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    r_avg <= (r_used == '0) ? '0 : div_quo[PERIOD_W-1:0];
                end
            end
            S_SCALE: begin
                r_thr <= thr_prod[THR_SHIFT +: THR_W];
            end
            S_EMIT: begin
                if (emit_go) begin
                    r_out_tick <= r_total;
                    r_out_avg  <= r_avg;
                    r_out_thr  <= r_thr;
                    r_out_used <= USED_OUT_W'(r_used);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_tick_count       = r_out_tick;
    assign o_average_period   = r_out_avg;
    assign o_glitch_threshold = r_out_thr;
    assign o_gaps_used        = r_out_used;

endmodule

// ===== design/efc_chk.sv =====
// Port-level checker for the edge frequency counter, bound to the top level.
// Depends on efc_pkg for widths.
module efc_chk
    import efc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [TS_W-1:0]       o_tick_count,
    input logic [PERIOD_W-1:0]   o_average_period,
    input logic [THR_W-1:0]      o_glitch_threshold,
    input logic [USED_OUT_W-1:0] o_gaps_used
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tick_count)
            && $stable(o_average_period) && $stable(o_gaps_used))
        else $error("report beat dropped or changed while stalled");

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gaps_used <= USED_OUT_W'(RING_DEPTH - 1))
        else $error("more gaps used than the ring holds");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_gaps_used == '0) |->
            (o_average_period == '0) && (o_glitch_threshold == '0))
        else $error("nonzero average with no gaps used");

    a_thr_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> PERIOD_W'(o_glitch_threshold) <= o_average_period)
        else $error("threshold exceeds average");

endmodule

bind edge_frequency_counter_deglitch efc_chk #(.RING_DEPTH(RING_DEPTH)) u_efc_chk (.*);

// ===== sim/tb_edge_frequency_counter_deglitch.sv =====
`timescale 1ns / 100ps
// Self-checking bench for edge_frequency_counter_deglitch: directed plan, then random traffic.
// Predicts tick count, mean period and glitch threshold per report; uses efc_pkg only.
module tb_edge_frequency_counter_deglitch;
    import efc_pkg::*;

    localparam int RING_N        = RING_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 80;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_BEATS   = 120;

    typedef enum logic {FN_EDGE = 1'b0, FN_REPORT = 1'b1} t_fn;
    typedef enum logic {ROW_BEAT = 1'b0, ROW_CFG = 1'b1} t_row_kind;

    typedef struct packed {
        logic [TS_W-1:0]       tick;
        logic [PERIOD_W-1:0]   avg;
        logic [THR_W-1:0]      thr;
        logic [USED_OUT_W-1:0] used;
    } t_period_report;

    typedef struct packed {
        t_row_kind             kind;
        t_fn                   fn;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [TS_W-1:0]       word;
        logic                  typed;
        t_period_report        want;
    } t_plan_row;

    localparam t_period_report NO_CHECK = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_func = 1'b0;
    logic [TS_W-1:0]       i_timestamp_us = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic [TS_W-1:0]       o_tick_count;
    logic [PERIOD_W-1:0]   o_average_period;
    logic [THR_W-1:0]      o_glitch_threshold;
    logic [USED_OUT_W-1:0] o_gaps_used;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [PERIOD_W-1:0]   i_cfg_wdata = '0;

    edge_frequency_counter_deglitch DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (i_func),
        .i_timestamp_us     (i_timestamp_us),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_tick_count       (o_tick_count),
        .o_average_period   (o_average_period),
        .o_glitch_threshold (o_glitch_threshold),
        .o_gaps_used        (o_gaps_used),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    // period predictor state
    logic [TS_W-1:0]     stamp_mem [RING_N] = '{default: '0};
    int unsigned         slot_ptr = 0;
    logic [TS_W-1:0]     edge_cnt = '0;
    logic [TS_W-1:0]     ref_time = '0;
    bit                  seen_edge = 1'b0;
    logic [THR_W-1:0]    gap_floor = '0;
    logic [PERIOD_W-1:0] lo_bound = MIN_PERIOD_RST;
    logic [PERIOD_W-1:0] hi_bound = MAX_PERIOD_RST;

    t_period_report pending_reports [$];

    int          errors = 0;
    int          edges_sent = 0;
    int          reports_sent = 0;
    int          reports_checked = 0;
    int          beats_sent = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    logic [31:0] wall_us = '0;

    t_plan_row directed_plan [24] = '{
        '{ROW_BEAT, FN_REPORT, REG_MIN_PERIOD, 32'hFFFF_FFFF, 1'b1,
          '{32'd0, 24'd0, 22'd0, 6'd0}},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'hFFFF_FC18, 1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd4000,      1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd9000,      1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd14000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd19000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd24000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd29000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd34000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd39000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_REPORT, REG_MIN_PERIOD, 32'd0,         1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd39500,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd39750,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd30000,     1'b0, NO_CHECK},
        '{ROW_BEAT, FN_REPORT, REG_MIN_PERIOD, 32'h5A5A_A5A5, 1'b0, NO_CHECK},
        '{ROW_CFG,  FN_EDGE,   REG_MIN_PERIOD, 32'h00FF_FFFF, 1'b0, NO_CHECK},
        '{ROW_CFG,  FN_EDGE,   REG_MAX_PERIOD, 32'd0,         1'b0, NO_CHECK},
        '{ROW_BEAT, FN_REPORT, REG_MIN_PERIOD, 32'd0,         1'b1,
          '{32'd10, 24'd0, 22'd0, 6'd0}},
        '{ROW_CFG,  FN_EDGE,   REG_MIN_PERIOD, 32'd0,         1'b0, NO_CHECK},
        '{ROW_CFG,  FN_EDGE,   REG_MAX_PERIOD, 32'h00FF_FFFF, 1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd16807214,  1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'd16807214,  1'b0, NO_CHECK},
        '{ROW_BEAT, FN_EDGE,   REG_MIN_PERIOD, 32'hFFFF_FFFF, 1'b0, NO_CHECK},
        '{ROW_BEAT, FN_REPORT, REG_MIN_PERIOD, 32'd0,         1'b0, NO_CHECK}
    };

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic track_edge(input logic [TS_W-1:0] stamp);
        logic [TS_W-1:0] gap;
        if (!seen_edge) begin
            seen_edge = 1'b1;
            ref_time  = stamp;
            edge_cnt  = edge_cnt + 1;
        end else begin
            gap = stamp - ref_time;
            stamp_mem[slot_ptr] = stamp;
            slot_ptr = (slot_ptr + 1) % RING_N;
            if (!gap[TS_W-1] && gap >= TS_W'(gap_floor)) begin
                edge_cnt = edge_cnt + 1;
                ref_time = stamp;
            end
        end
    endtask

    function automatic t_period_report compute_period_report();
        t_period_report  rep;
        int unsigned     pos;
        int unsigned     nxt;
        int unsigned     used;
        logic [TS_W-1:0] gap;
        logic [TS_W-1:0] sum;
        logic [TS_W-1:0] avg;
        logic [TS_W-1:0] thr;
        pos  = slot_ptr;
        used = 0;
        sum  = '0;
        avg  = '0;
        for (int k = 0; k < RING_N - 1; k++) begin
            nxt = (pos + 1) % RING_N;
            gap = stamp_mem[nxt] - stamp_mem[pos];
            if (!gap[TS_W-1] && gap != 0 && gap > lo_bound && gap < hi_bound) begin
                sum  = sum + gap;
                used = used + 1;
            end
            pos = nxt;
        end
        if (used > 0)
            avg = sum / used;
        avg       = {8'b0, avg[PERIOD_W-1:0]};
        thr       = (avg * THR_NUM) / THR_DEN;
        gap_floor = thr[THR_W-1:0];
        rep.tick  = edge_cnt;
        rep.avg   = avg[PERIOD_W-1:0];
        rep.thr   = thr[THR_W-1:0];
        rep.used  = used[USED_OUT_W-1:0];
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : take_report
        t_period_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t ns: report beat with none expected, got tick %0d avg %0d",
                         $time, o_tick_count, o_average_period);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("tick_count", want.tick, o_tick_count);
                check_field("average_period", 32'(want.avg), 32'(o_average_period));
                check_field("glitch_threshold", 32'(want.thr), 32'(o_glitch_threshold));
                check_field("gaps_used", 32'(want.used), 32'(o_gaps_used));
                reports_checked++;
            end
        end
    end

    // called and returning at a falling edge
    task automatic send_beat(input t_fn fn, input logic [TS_W-1:0] stamp,
                             input logic typed, input t_period_report want);
        t_period_report pred;
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid     <= 1'b1;
        i_func         <= fn;
        i_timestamp_us <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        if (fn == FN_REPORT) begin
            pred = compute_period_report();
            pending_reports.push_back(typed ? want : pred);
            reports_sent++;
        end else begin
            track_edge(stamp);
            edges_sent++;
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [PERIOD_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= sel;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (sel == REG_MIN_PERIOD)
            lo_bound = data;
        else
            hi_bound = data;
    endtask

    // steady edge train with jitter and stray glitches, closed by a report; else noise
    task automatic send_sequence();
        int unsigned period;
        int unsigned n_edges;
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(1, 6))
                send_beat(t_fn'($urandom_range(1)), $urandom(), 1'b0, NO_CHECK);
        end else begin
            case ($urandom_range(9))
                0:       period = $urandom_range(24'hFFFFFF);
                1:       period = $urandom_range(20);
                default: period = $urandom_range(800, 60000);
            endcase
            if ($urandom_range(1))
                wall_us = $urandom();
            n_edges = $urandom_range(3, 12);
            repeat (n_edges) begin
                wall_us = wall_us + period + $urandom_range(period / 16);
                send_beat(FN_EDGE, wall_us, 1'b0, NO_CHECK);
                if ($urandom_range(9) == 0)
                    send_beat(FN_EDGE, wall_us + $urandom_range(period / 4), 1'b0, NO_CHECK);
            end
            send_beat(FN_REPORT, $urandom(), 1'b0, NO_CHECK);
        end
    endtask

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int phase_end;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_CFG)
                write_reg(directed_plan[r].reg_sel, directed_plan[r].word[PERIOD_W-1:0]);
            else
                send_beat(directed_plan[r].fn, directed_plan[r].word,
                          directed_plan[r].typed, directed_plan[r].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = 0;
            stall_pct    = 0;
            case (ph)
                0: begin
                    write_reg(REG_MIN_PERIOD, MIN_PERIOD_RST);
                    write_reg(REG_MAX_PERIOD, MAX_PERIOD_RST);
                end
                1: begin
                    send_gap_pct = 75;
                    write_reg(REG_MIN_PERIOD, '0);
                    write_reg(REG_MAX_PERIOD, '1);
                end
                2: begin
                    stall_pct = 75;
                    write_reg(REG_MIN_PERIOD, PERIOD_W'($urandom_range(500, 3000)));
                    write_reg(REG_MAX_PERIOD, PERIOD_W'($urandom_range(20000, 100000)));
                end
                default: begin
                    send_gap_pct = 33;
                    stall_pct    = 33;
                    write_reg(REG_MIN_PERIOD, PERIOD_W'($urandom_range(24'hFFFFFF)));
                    write_reg(REG_MAX_PERIOD, PERIOD_W'($urandom_range(24'hFFFFFF)));
                end
            endcase
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                send_sequence();
                // now and then, hold off until the block has drained
                if ($urandom_range(7) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Run covered %0d edge beats and %0d report beats over four traffic phases,",
                 edges_sent, reports_sent);
        $display("with %0d reports compared field by field against the period predictor.",
                 reports_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
